### rtl/dss_pkg.sv
// Shared types, constants and control bundles of the disk seek scheduler.
package dss_pkg;

  localparam int CYL_W      = 16;
  localparam int SEEK_W     = 22;
  localparam int DCYL_W     = 17;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int MAX_REQUESTS_DEF = 64;

  localparam logic [SEEK_W-1:0] SEEK_MAX = 22'h3FFFFF;

  // Scheduling policies; the spare code behaves as first come first served.
  localparam logic [MODE_W-1:0] MODE_FCFS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYLS = 2'd2;

  localparam logic [DCYL_W-1:0] CYLS_RESET = 17'h10000;

  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             last_request;
  } req_t;

  typedef struct packed {
    logic [CYL_W-1:0]  served_cylinder;
    logic [SEEK_W-1:0] seek_total;
    logic              end_of_order;
    logic              overflow_flag;
  } rsp_t;

  typedef struct packed {
    logic store;
    logic sort_init;
    logic key_latch;
    logic shift;
    logic place;
    logic scan_init;
    logic scan_step;
    logic total;
    logic emit_init;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic sorted_mode;
    logic n_small;
    logic key_gt;
    logic j_one;
    logic i_last;
    logic scan_last;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

### rtl/disk_seek_scheduler.sv
// Disk seek scheduler: batches cylinder requests and emits their service order.
//
// Requests arrive on the req channel, one per cycle while req_stall is low.
// Each is stored until one marked last_request arrives; the block then stalls
// requests and produces the whole service order on the rsp channel, one result
// per stored request. The final result carries end_of_order and seek_total.
// Requests beyond MAX_REQUESTS are dropped and overflow_flag is set on every
// result of that batch. The user must write policy_mode, head_start and
// disk_cylinders through the cfg port only while the block is idle; the block
// itself does not enforce this. After the last request, first come first
// served sets up emission and then gives its first result. SCAN and circular
// SCAN first run an insertion sort in the sorted store, shifting at most
// n*(n-1)/2 entries, then a scan over the sorted store, the seek total and
// the emission set-up; the single read port of that store paces these steps.
// Results then leave at one per cycle; a stall on rsp holds the result
// register and pauses emission. Requests are taken again the cycle after the
// final result is loaded. Reset empties the batch and restores the register
// defaults; the stores need no clearing.
module disk_seek_scheduler #(
  parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  dss_pkg::req_t                  req_data,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output dss_pkg::rsp_t                  rsp_data,
  input  logic                           cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .last_request (req_data.last_request),
    .req_stall    (req_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  dss_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

### rtl/dss_datapath.sv
// Datapath: request stores, insertion sort, head scan, seek totals and result register.
module dss_datapath #(
  parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dss_pkg::req_t                  req_data,
  input  dss_pkg::cmd_t                  cmd,
  output dss_pkg::stat_t                 stat,
  input  logic                           cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output dss_pkg::rsp_t                  rsp_data
);
  import dss_pkg::*;

  localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int TW = 24;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);
  localparam logic [CW-1:0] ONE     = CW'(1);

  logic [MODE_W-1:0] mode;
  logic [CYL_W-1:0]  head;
  logic [DCYL_W-1:0] cyls;

  logic [CW-1:0]     count;
  logic              dropped;
  logic              sorted_mode;
  logic              scan_mode;
  logic              has_room;

  logic [CYL_W-1:0]  req_mem [MAX_REQUESTS];
  logic [CYL_W-1:0]  srt_mem [MAX_REQUESTS];
  logic [CYL_W-1:0]  req_q;
  logic [CYL_W-1:0]  srt_q;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              srt_we;
  logic [IW-1:0]     srt_wa;
  logic [CYL_W-1:0]  srt_wd;

  logic [CW-1:0]     i;
  logic [CW-1:0]     j;
  logic [CW-1:0]     i_m1;
  logic [CW-1:0]     i_p1;
  logic [CW-1:0]     j_m2;
  logic [CYL_W-1:0]  key;

  logic [CW-1:0]     idx;
  logic [CW-1:0]     idx_p1;
  logic              found;
  logic [CW-1:0]     s_idx;
  logic [CYL_W-1:0]  lo;
  logic [CYL_W-1:0]  hi;
  logic [CYL_W-1:0]  below;

  logic signed [TW-1:0] h_s;
  logic signed [TW-1:0] end_s;
  logic signed [TW-1:0] total_raw;
  logic [SEEK_W-1:0]    total_clamped;
  logic [SEEK_W-1:0]    total_q;

  logic [CW-1:0]     addr;
  logic [CW-1:0]     addr_p1;
  logic [CW-1:0]     addr_next;
  logic              phase;
  logic              phase_next;
  logic [CW-1:0]     start_addr;
  logic              start_phase;
  logic [CW-1:0]     left;
  logic [CYL_W-1:0]  pos;
  logic [SEEK_W-1:0] facc;
  logic [CYL_W-1:0]  rdv;
  logic [CYL_W-1:0]  diff;
  logic [SEEK_W:0]   facc_sum;
  logic [SEEK_W-1:0] facc_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FCFS;
      head <= '0;
      cyls <= CYLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: mode <= cfg_data[MODE_W-1:0];
        CFG_HEAD: head <= cfg_data[CYL_W-1:0];
        CFG_CYLS: cyls <= cfg_data[DCYL_W-1:0];
        default: ;
      endcase
    end
  end

  assign sorted_mode = (mode == MODE_SCAN) || (mode == MODE_CSCAN);
  assign scan_mode   = (mode == MODE_SCAN);
  assign has_room    = (count < MAX_CNT);

  assign i_m1   = i - ONE;
  assign i_p1   = i + ONE;
  assign j_m2   = j - CW'(2);
  assign idx_p1 = idx + ONE;

  // Emission walks the upper group upwards, then the lower group in the policy's direction.
  always_comb begin
    start_phase = 1'b0;
    start_addr  = '0;
    if (sorted_mode) begin
      if (s_idx != count) begin
        start_addr = s_idx;
      end else begin
        start_phase = 1'b1;
        start_addr  = scan_mode ? (s_idx - ONE) : '0;
      end
    end
  end

  assign addr_p1 = addr + ONE;

  always_comb begin
    phase_next = phase;
    addr_next  = addr_p1;
    if (sorted_mode) begin
      if (!phase) begin
        if (addr_p1 == count) begin
          phase_next = 1'b1;
          addr_next  = scan_mode ? (s_idx - ONE) : '0;
        end
      end else if (scan_mode) begin
        addr_next = addr - ONE;
      end
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    srt_we  = cmd.store && has_room;
    srt_wa  = count[IW-1:0];
    srt_wd  = req_data.request_cylinder;
    if (cmd.sort_init) begin
      rd_en   = 1'b1;
      rd_addr = IW'(1);
    end
    if (cmd.key_latch) begin
      rd_en   = 1'b1;
      rd_addr = i_m1[IW-1:0];
    end
    if (cmd.shift) begin
      srt_we  = 1'b1;
      srt_wa  = j[IW-1:0];
      srt_wd  = srt_q;
      rd_en   = 1'b1;
      rd_addr = j_m2[IW-1:0];
    end
    if (cmd.place) begin
      srt_we  = 1'b1;
      srt_wa  = j[IW-1:0];
      srt_wd  = key;
      rd_en   = 1'b1;
      rd_addr = i_p1[IW-1:0];
    end
    if (cmd.scan_init) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end
    if (cmd.scan_step) begin
      rd_en   = 1'b1;
      rd_addr = idx_p1[IW-1:0];
    end
    if (cmd.emit_init) begin
      rd_en   = 1'b1;
      rd_addr = start_addr[IW-1:0];
    end
    if (cmd.emit_load) begin
      rd_en   = 1'b1;
      rd_addr = addr_next[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && has_room) begin
      req_mem[count[IW-1:0]] <= req_data.request_cylinder;
    end
    if (rd_en) begin
      req_q <= req_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[srt_wa] <= srt_wd;
    end
    if (rd_en) begin
      srt_q <= srt_mem[rd_addr];
    end
  end

  // Totals are worked out signed, so that an odd disk size clamps rather than wraps.
  always_comb begin
    h_s   = $signed(TW'(head));
    end_s = $signed(TW'(cyls)) - $signed(TW'(1));
    if (s_idx == '0) begin
      total_raw = $signed(TW'(hi)) - h_s;
    end else if (scan_mode) begin
      total_raw = (end_s <<< 1) - h_s - $signed(TW'(lo));
    end else begin
      total_raw = end_s - h_s + $signed(TW'(below));
    end
    if (total_raw < 0) begin
      total_clamped = '0;
    end else if (total_raw > $signed(TW'(SEEK_MAX))) begin
      total_clamped = SEEK_MAX;
    end else begin
      total_clamped = total_raw[SEEK_W-1:0];
    end
  end

  assign rdv      = sorted_mode ? srt_q : req_q;
  assign diff     = (rdv >= pos) ? (rdv - pos) : (pos - rdv);
  assign facc_sum = {1'b0, facc} + (SEEK_W + 1)'(diff);
  assign facc_sat = (facc_sum > {1'b0, SEEK_MAX}) ? SEEK_MAX : facc_sum[SEEK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (has_room) begin
          count <= count + ONE;
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.emit_load && stat.emit_last) begin
        count   <= '0;
        dropped <= 1'b0;
      end
      if (cmd.emit_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      i <= ONE;
    end
    if (cmd.key_latch) begin
      key <= srt_q;
      j   <= i;
    end
    if (cmd.shift) begin
      j <= j - ONE;
    end
    if (cmd.place) begin
      i <= i_p1;
    end
    if (cmd.scan_init) begin
      idx   <= '0;
      found <= 1'b0;
      s_idx <= count;
    end
    if (cmd.scan_step) begin
      if (idx == '0) begin
        lo <= srt_q;
      end
      hi <= srt_q;
      if (!found && (srt_q > head)) begin
        found <= 1'b1;
        s_idx <= idx;
      end
      if (srt_q <= head) begin
        below <= srt_q;
      end
      idx <= idx_p1;
    end
    if (cmd.total) begin
      total_q <= total_clamped;
    end
    if (cmd.emit_init) begin
      addr  <= start_addr;
      phase <= start_phase;
      left  <= count;
      pos   <= head;
      facc  <= '0;
    end
    if (cmd.emit_load) begin
      addr  <= addr_next;
      phase <= phase_next;
      left  <= left - ONE;
      pos   <= rdv;
      facc  <= facc_sat;
      rsp_data.served_cylinder <= rdv;
      rsp_data.end_of_order    <= stat.emit_last;
      rsp_data.overflow_flag   <= dropped;
      if (stat.emit_last) begin
        rsp_data.seek_total <= sorted_mode ? total_q : facc_sat;
      end else begin
        rsp_data.seek_total <= '0;
      end
    end
  end

  assign stat.sorted_mode = sorted_mode;
  assign stat.n_small     = (count <= ONE);
  assign stat.key_gt      = (srt_q > key);
  assign stat.j_one       = (j == ONE);
  assign stat.i_last      = (i_p1 >= count);
  assign stat.scan_last   = (idx_p1 == count);
  assign stat.emit_last   = (left == ONE);
  assign stat.out_free    = !rsp_valid || !rsp_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= MAX_CNT)
    else $error("request count beyond store capacity");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (!rsp_valid || !rsp_stall))
    else $error("result register overwritten while a result waits");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load && stat.emit_last) |=> (count == '0 && !dropped))
    else $error("batch state not cleared after the final result");

  a_shift_j: assert property (@(posedge clk) disable iff (rst) cmd.shift |-> (j != '0))
    else $error("sort shift below the bottom of the store");

endmodule

### rtl/dss_ctrl.sv
// Controller: sequences loading, sorting, scanning and emission of a batch.
module dss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           last_request,
  output logic           req_stall,
  input  dss_pkg::stat_t stat,
  output dss_pkg::cmd_t  cmd
);
  import dss_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SORT,
    S_KEY,
    S_CMP,
    S_PLACE,
    S_SCAN0,
    S_SCAN,
    S_TOTAL,
    S_EMIT0,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = req_valid && !req_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.store = accept;
        if (accept && last_request) begin
          state_next = stat.sorted_mode ? S_SORT : S_EMIT0;
        end
      end
      S_SORT: begin
        if (stat.n_small) begin
          state_next = S_SCAN0;
        end else begin
          cmd.sort_init = 1'b1;
          state_next    = S_KEY;
        end
      end
      S_KEY: begin
        cmd.key_latch = 1'b1;
        state_next    = S_CMP;
      end
      S_CMP: begin
        if (stat.key_gt) begin
          cmd.shift  = 1'b1;
          state_next = stat.j_one ? S_PLACE : S_CMP;
        end else begin
          cmd.place  = 1'b1;
          state_next = stat.i_last ? S_SCAN0 : S_KEY;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = stat.i_last ? S_SCAN0 : S_KEY;
      end
      S_SCAN0: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_TOTAL;
        end
      end
      S_TOTAL: begin
        cmd.total  = 1'b1;
        state_next = S_EMIT0;
      end
      S_EMIT0: begin
        cmd.emit_init = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) begin
            state_next = S_LOAD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      req_stall <= 1'b0;
    end else begin
      state     <= state_next;
      req_stall <= (state_next != S_LOAD);
    end
  end

endmodule
